// ----- rtl/assert_macros.svh -----
// Assertion macros used by the scanner core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/bks_pkg.sv -----
// Shared constants and types for the bracket keyword index scanner.
`timescale 1ns / 1ps

package bks_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int OUT_BITS     = 32;
    localparam int CNT_BITS     = 28;
    localparam int MODE_BITS    = 3;

    localparam logic [CNT_BITS-1:0] MAX_ENTRIES_RST = {CNT_BITS{1'b1}};

    localparam logic [7:0] CHAR_NL     = 8'h0a;
    localparam logic [7:0] CHAR_LT     = 8'h3c;
    localparam logic [7:0] CHAR_GT     = 8'h3e;
    localparam logic [7:0] CHAR_LBRACK = 8'h5b;
    localparam logic [7:0] CHAR_RBRACK = 8'h5d;
    localparam logic [7:0] HIGH_MIN    = 8'd127;

    // Register indexes (byte address bit 2 selects the word)
    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef struct packed {
        logic [OUT_BITS-1:0] keyword_anchor;
        logic [OUT_BITS-1:0] line_start;
        logic                overflow;
    } t_result;

endpackage

// ----- rtl/bks_regs.sv -----
// APB configuration register holding the entry limit.
`timescale 1ns / 1ps

module bks_regs
    import bks_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [CNT_BITS-1:0] o_max_entries
);

    logic [CNT_BITS-1:0] r_max_entries;
    logic                wr_en;

    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES);
    assign pready = 1'b1;

    // Upper data bits and byte-lane bits have no storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (wr_en) begin
            r_max_entries <= pwdata[CNT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_ENTRIES) begin
            prdata = {{(32-CNT_BITS){1'b0}}, r_max_entries};
        end
    end

    assign o_max_entries = r_max_entries;

endmodule

// ----- rtl/bks_core.sv -----
// Input register, scan state and single-pass keyword detection.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bks_core
    import bks_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic [CNT_BITS-1:0] i_max_entries,
    input  logic                i_out_free,
    output logic                o_emit,
    output t_result             o_result
);

    localparam logic [MODE_BITS-1:0] MODE_SEEK_OPEN    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_FIELD_START  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_IN_RUN       = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_OUTSIDE_RUN  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_SKIP_BRACKET = 3'd4;

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    logic [MODE_BITS-1:0]     r_mode;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_line_start;
    logic [POSITION_BITS-1:0] r_pending;
    logic [CNT_BITS-1:0]      r_entries;
    logic                     r_stopped;

    logic [MODE_BITS-1:0]     n_mode;
    logic [MODE_BITS-1:0]     mode_after_outside;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_pending;
    logic [CNT_BITS:0]        n_count;
    logic                     consume;
    logic                     live;
    logic                     is_high;
    logic                     is_nl;
    logic                     run_end;
    logic                     ovf;
    logic [POSITION_BITS+OUT_BITS-1:0] anchor_ext;
    logic [POSITION_BITS+OUT_BITS-1:0] line_ext;

    assign consume = r_in_valid && i_out_free;
    assign o_ready = !r_in_valid || i_out_free;
    assign live    = consume && !r_stopped;
    assign is_high = r_in_byte >= HIGH_MIN;
    assign is_nl   = r_in_byte == CHAR_NL;
    assign n_pos   = r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Where a non-high byte lands once it falls through to the outside-run mode
    always_comb begin
        if (r_in_byte == CHAR_GT) begin
            mode_after_outside = MODE_SEEK_OPEN;
        end else if (r_in_byte == CHAR_LBRACK) begin
            mode_after_outside = MODE_SKIP_BRACKET;
        end else begin
            mode_after_outside = MODE_OUTSIDE_RUN;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_pending = r_pending;
        run_end   = 1'b0;
        unique case (r_mode)
            MODE_FIELD_START: begin
                if (is_high) begin
                    n_pending = r_pos;
                    n_mode    = MODE_IN_RUN;
                end else begin
                    n_mode = mode_after_outside;
                end
            end
            MODE_IN_RUN: begin
                if (!is_high) begin
                    run_end = 1'b1;
                    n_mode  = mode_after_outside;
                end
            end
            MODE_OUTSIDE_RUN: begin
                if (r_in_byte == CHAR_GT || r_in_byte == CHAR_LBRACK) begin
                    n_mode = mode_after_outside;
                end else if (is_high) begin
                    // restart a field and open a run on the same byte
                    n_pending = r_pos;
                    n_mode    = MODE_IN_RUN;
                end
            end
            MODE_SKIP_BRACKET: begin
                if (r_in_byte == CHAR_RBRACK) begin
                    n_mode = MODE_FIELD_START;
                end
            end
            default: begin
                n_mode = (r_in_byte == CHAR_LT) ? MODE_FIELD_START : MODE_SEEK_OPEN;
            end
        endcase
    end

    assign n_count = {1'b0, r_entries} + 1'b1;
    assign ovf     = n_count > {1'b0, i_max_entries};
    assign o_emit  = live && !is_nl && run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SEEK_OPEN;
            r_pos        <= '0;
            r_line_start <= {{(POSITION_BITS-1){1'b0}}, 1'b1};
            r_pending    <= '0;
            r_entries    <= '0;
            r_stopped    <= 1'b0;
        end else if (live) begin
            r_pos <= n_pos;
            if (is_nl) begin
                r_line_start <= n_pos + 1'b1;
            end else begin
                r_mode    <= n_mode;
                r_pending <= n_pending;
                if (run_end) begin
                    if (ovf) begin
                        r_stopped <= 1'b1;
                    end else begin
                        r_entries <= n_count[CNT_BITS-1:0];
                    end
                end
            end
        end
    end

    assign anchor_ext = {{OUT_BITS{1'b0}}, r_pending};
    assign line_ext   = {{OUT_BITS{1'b0}}, r_line_start};

    assign o_result.keyword_anchor = anchor_ext[OUT_BITS-1:0];
    assign o_result.line_start     = line_ext[OUT_BITS-1:0];
    assign o_result.overflow       = ovf;

    `ASSERT_CLK(a_ovf_halts, (o_emit && ovf) |=> r_stopped, "overflow entry did not halt")
    `ASSERT_CLK(a_halt_sticks, r_stopped |=> r_stopped, "halt cleared without reset")
    `ASSERT_NEVER(a_no_emit_halted, r_stopped && o_emit, "entry emitted while halted")
    `ASSERT_CLK(a_count_adv, (o_emit && !ovf) |=> (r_entries == $past(n_count[CNT_BITS-1:0])),
        "entry count did not advance")

endmodule

// ----- rtl/bks_out.sv -----
// Result register on the output channel.
`timescale 1ns / 1ps

module bks_out
    import bks_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_emit,
    input  t_result             i_result,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OUT_BITS-1:0] o_keyword_anchor,
    output logic [OUT_BITS-1:0] o_line_start,
    output logic                o_overflow
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_valid          = r_valid;
    assign o_keyword_anchor = r_result.keyword_anchor;
    assign o_line_start     = r_result.line_start;
    assign o_overflow       = r_result.overflow;

endmodule

// ----- rtl/bracket_keyword_index_scanner.sv -----
// Top level of the bracket keyword index scanner.
//
// Takes one dictionary byte per cycle, back to back while input ready is high, and emits
// an index entry (anchor position, line start, overflow flag) when a run of bytes 127 or
// above inside a <...> field ends. A byte is held in the input register and its entry is
// written to the output register when the byte is consumed; all scan work is combinational.
// Input ready drops only while the input register holds a byte and a result waits
// unaccepted on the output. After an overflow entry the block keeps taking bytes and
// drops them until reset. max_entries is written over APB at byte address 0.
`timescale 1ns / 1ps

module bracket_keyword_index_scanner
    import bks_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OUT_BITS-1:0] o_keyword_anchor,
    output logic [OUT_BITS-1:0] o_line_start,
    output logic                o_overflow
);

    logic [CNT_BITS-1:0] max_entries;
    logic                out_free;
    logic                emit;
    t_result             result;

    bks_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_entries (max_entries)
    );

    bks_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_max_entries (max_entries),
        .i_out_free    (out_free),
        .o_emit        (emit),
        .o_result      (result)
    );

    bks_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_emit           (emit),
        .i_result         (result),
        .o_free           (out_free),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_keyword_anchor (o_keyword_anchor),
        .o_line_start     (o_line_start),
        .o_overflow       (o_overflow)
    );

endmodule
